FILE: rtl/mep_pkg.sv
// ----------------------------------------------------------------------------
// mep_pkg
// shared constants for the modular exponentiation core (prime 1000000007)
// ----------------------------------------------------------------------------
package mep_pkg;

  localparam int unsigned EXP_BITS = 32;   // exponent bits scanned, 1..64
  localparam int unsigned BASE_W   = 32;
  localparam int unsigned EXPO_W   = 32;
  localparam int unsigned RES_W    = 30;
  localparam int unsigned MUL_W    = 32;
  localparam int unsigned PROD_W   = 2 * MUL_W;

  // modulus and its small multiples for the final correction
  localparam logic [RES_W-1:0] PRIME = 30'd1000000007;
  localparam logic [MUL_W-1:0] P1 = 32'd1000000007;
  localparam logic [MUL_W-1:0] P2 = 32'd2000000014;
  localparam logic [MUL_W-1:0] P3 = 32'd3000000021;
  localparam logic [MUL_W-1:0] P4 = 32'd4000000028;

  // barrett reduction with k = 30: q1 = x >> 29, q3 = (q1 * mu) >> 31
  localparam int unsigned RED_K = 30;
  localparam logic [MUL_W-1:0] BARRETT_MU = 32'((64'd1 << (2 * RED_K)) / 64'd1000000007);

  // exponent bits at or above EXP_BITS are dropped at load
  localparam logic [EXPO_W-1:0] EXP_MASK = (EXP_BITS >= EXPO_W) ? {EXPO_W{1'b1}} :
                                           EXPO_W'((64'd1 << EXP_BITS) - 64'd1);

endpackage

FILE: rtl/mep_if.sv
// ----------------------------------------------------------------------------
// mep_if
// valid/ready channels for operands and results
// ----------------------------------------------------------------------------
interface mep_in_if;
  logic                        valid;
  logic                        ready;
  logic [mep_pkg::BASE_W-1:0]  base;
  logic [mep_pkg::EXPO_W-1:0]  exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink   (input valid, input base, input exponent, output ready);
endinterface

interface mep_out_if;
  logic                        valid;
  logic                        ready;
  logic [mep_pkg::RES_W-1:0]   power_mod;

  modport source (output valid, output power_mod, input ready);
  modport sink   (input valid, input power_mod, output ready);
endinterface

FILE: rtl/modular_exponentiation_prime_core.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_prime_core
// base ^ exponent mod 1000000007 by right-to-left square-and-multiply
// ----------------------------------------------------------------------------
// latency: the sequencer runs one pass of m0..m6 per exponent bit up to n, where n is
//   the position of the highest set exponent bit plus one (0 for a zero exponent)
// throughput: one transaction at a time, since operands are taken only in idle; the single shared
//   multiplier carries three barrett products for each of two modmuls per bit
// reset: synchronous active-high rst returns the sequencer to idle and empties
//   the result register; no arithmetic state needs clearing
module modular_exponentiation_prime_core (
  input  logic       clk,
  input  logic       rst,
  mep_in_if.sink     operands,
  mep_out_if.source  result
);
  import mep_pkg::*;

  localparam int unsigned RES_K_SHIFT = RED_K - 1;
  localparam int unsigned Q3_SHIFT    = RED_K + 1;

  // one-hot sequencer
  // m0..m6 interleave the multiply (acc*cur) and the square (cur*cur)
  // through the barrett steps on the one multiplier
  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_RED  = 10'b00_0000_0010,
    ST_M0   = 10'b00_0000_0100,
    ST_M1   = 10'b00_0000_1000,
    ST_M2   = 10'b00_0001_0000,
    ST_M3   = 10'b00_0010_0000,
    ST_M4   = 10'b00_0100_0000,
    ST_M5   = 10'b00_1000_0000,
    ST_M6   = 10'b01_0000_0000,
    ST_FIN  = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  // working registers
  logic [BASE_W-1:0]   base_val;   // captured base, reduced in ST_RED
  logic [EXPO_W-1:0]   expo;       // remaining exponent, shifted right per bit
  logic [RES_W-1:0]    acc;        // running product
  logic [RES_W-1:0]    cur;        // current base power
  logic [2*RES_W-1:0]  xa;         // acc * cur, full product
  logic [2*RES_W-1:0]  xc;         // cur * cur, full product
  logic [RES_W:0]      q3a;        // barrett quotient estimate, multiply lane
  logic [RES_W:0]      q3c;        // barrett quotient estimate, square lane
  logic [RES_W-1:0]    res;        // output register payload
  logic                res_valid;

  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]   prod;
  logic [MUL_W-1:0]    fix_in;
  logic [RES_W-1:0]    fix_out;
  logic                accept;
  logic                res_load;

  assign accept   = operands.valid && operands.ready;
  assign res_load = (state == ST_FIN) && (!res_valid || result.ready);

  assign operands.ready  = (state == ST_IDLE);
  assign result.valid    = res_valid;
  assign result.power_mod = res;

  // multiplier operand selection per step
  always_comb begin
    case (state)
      ST_M0: begin
        mul_a = MUL_W'(acc);
        mul_b = MUL_W'(cur);
      end
      ST_M1: begin
        mul_a = MUL_W'(cur);
        mul_b = MUL_W'(cur);
      end
      ST_M2: begin
        mul_a = MUL_W'(xa[2*RES_W-1:RES_K_SHIFT]);
        mul_b = BARRETT_MU;
      end
      ST_M3: begin
        mul_a = MUL_W'(xc[2*RES_W-1:RES_K_SHIFT]);
        mul_b = BARRETT_MU;
      end
      ST_M4: begin
        mul_a = MUL_W'(q3a);
        mul_b = P1;
      end
      ST_M5: begin
        mul_a = MUL_W'(q3c);
        mul_b = P1;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mep_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // remainder x - q3*p stays below 3p, so 32-bit wraparound arithmetic is exact
  always_comb begin
    case (state)
      ST_RED:  fix_in = base_val;
      ST_M5:   fix_in = xa[MUL_W-1:0] - prod[MUL_W-1:0];
      default: fix_in = xc[MUL_W-1:0] - prod[MUL_W-1:0];
    endcase
  end

  mep_fix u_fix (
    .val (fix_in),
    .res (fix_out)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_RED;
      ST_RED: begin
        state_next = (expo == '0) ? ST_FIN : ST_M0;
      end
      ST_M0:   state_next = ST_M1;
      ST_M1:   state_next = ST_M2;
      ST_M2:   state_next = ST_M3;
      ST_M3:   state_next = ST_M4;
      ST_M4:   state_next = ST_M5;
      ST_M5:   state_next = ST_M6;
      ST_M6: begin
        // stop once no set exponent bit remains
        state_next = (expo[EXPO_W-1:1] == '0) ? ST_FIN : ST_M0;
      end
      ST_FIN:  if (res_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= acc;
    end
    case (state)
      ST_IDLE: begin
        if (accept) begin
          base_val <= operands.base;
          expo     <= operands.exponent & EXP_MASK;
        end
      end
      ST_RED: begin
        cur <= fix_out;
        acc <= RES_W'(1);
      end
      ST_M1: xa  <= prod[2*RES_W-1:0];
      ST_M2: xc  <= prod[2*RES_W-1:0];
      ST_M3: q3a <= prod[Q3_SHIFT+RES_W:Q3_SHIFT];
      ST_M4: q3c <= prod[Q3_SHIFT+RES_W:Q3_SHIFT];
      ST_M5: begin
        // multiply only where the current exponent bit is set
        if (expo[0]) begin
          acc <= fix_out;
        end
      end
      ST_M6: begin
        cur  <= fix_out;
        expo <= expo >> 1;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/mep_mul.sv
// ----------------------------------------------------------------------------
// mep_mul
// shared 32x32 unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module mep_mul (
  input  logic                        clk,
  input  logic [mep_pkg::MUL_W-1:0]   a,
  input  logic [mep_pkg::MUL_W-1:0]   b,
  output logic [mep_pkg::PROD_W-1:0]  prod
);
  import mep_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

FILE: rtl/mep_fix.sv
// ----------------------------------------------------------------------------
// mep_fix
// reduces a 32-bit value (below 5 * prime) into 0 .. prime-1
// ----------------------------------------------------------------------------
module mep_fix (
  input  logic [mep_pkg::MUL_W-1:0]  val,
  output logic [mep_pkg::RES_W-1:0]  res
);
  import mep_pkg::*;

  logic [MUL_W-1:0] sel;

  always_comb begin
    if (val >= P4) begin
      sel = val - P4;
    end else if (val >= P3) begin
      sel = val - P3;
    end else if (val >= P2) begin
      sel = val - P2;
    end else if (val >= P1) begin
      sel = val - P1;
    end else begin
      sel = val;
    end
  end

  assign res = sel[RES_W-1:0];

endmodule

FILE: test/tb_modular_exponentiation_prime_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation_prime_core
// drives base/exponent transactions into the core under random valid and
// ready gaps and checks every power_mod against a square-and-multiply model
// ----------------------------------------------------------------------------
module tb_modular_exponentiation_prime_core;

  import mep_pkg::*;

  // modulus widened for the 64-bit products of the model
  localparam logic [63:0] MODULUS = 64'(P1);

  // worst case: the longest exponent scan plus a long result stall
  localparam int unsigned STALL_LIMIT = 4000;
  // quiet time after the last result, a bit above the longest latency
  localparam int unsigned DRAIN_CYCLES = 300;

  localparam int unsigned RANDOM_OPS  = 1050;
  localparam int unsigned IDLE_PCT    = 27;
  // transaction counts between which neither side idles
  localparam int unsigned CALM_FIRST  = 400;
  localparam int unsigned CALM_LAST   = 600;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic [EXPO_W-1:0] exponent;
  } operand_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mep_in_if  operands ();
  mep_out_if result ();

  modular_exponentiation_prime_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .operands (operands.sink),
    .result   (result.source)
  );

  // operand transactions still to be driven, and powers still owed by the core
  operand_t           pending_ops[$];
  logic [RES_W-1:0]   expected_powers[$];
  operand_t           next_op;

  int unsigned total_ops;
  int unsigned sent_ops;
  int unsigned accepted_ops;
  int unsigned received_powers;
  int unsigned mismatch_count;
  int unsigned stall_cycles;
  logic        operand_taken;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // base^exponent mod 1000000007, right-to-left over the scanned exponent bits
  function automatic logic [RES_W-1:0] pow_mod_prime(input logic [BASE_W-1:0] b,
                                                     input logic [EXPO_W-1:0] e);
    logic [63:0] square;
    logic [63:0] product;
    logic [63:0] ex;
    int unsigned idx;
    square  = 64'(b) % MODULUS;   // bases at or above the prime fold down here
    product = 64'd1;              // zero exponent leaves this at 1, even for 0^0
    ex      = 64'(e);
    for (idx = 0; idx < EXP_BITS && idx < 64; idx++) begin
      if (ex[idx]) begin
        product = (product * square) % MODULUS;
      end
      square = (square * square) % MODULUS;
    end
    return product[RES_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic queue_op(input logic [BASE_W-1:0] b, input logic [EXPO_W-1:0] e);
    operand_t op;
    op.base     = b;
    op.exponent = e;
    pending_ops = {pending_ops, op};
  endtask

  // --------------------------------------------------------------------------
  // operand driver: changes only at the falling edge, one nonblocking
  // assignment per signal; valid is held until the transaction is taken
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      operands.valid <= 1'b0;
    end else if (!operands.valid || operand_taken) begin
      // the calm window keeps valid high back to back for a stretch
      if (pending_ops.size() != 0 &&
          ((sent_ops >= CALM_FIRST && sent_ops < CALM_LAST) ||
           $urandom_range(99) >= IDLE_PCT)) begin
        next_op = pending_ops.pop_front();
        sent_ops++;
        operands.valid    <= 1'b1;
        operands.base     <= next_op.base;
        operands.exponent <= next_op.exponent;
      end else begin
        operands.valid <= 1'b0;
      end
    end
  end

  // result ready: random back-pressure, none inside the calm window
  always @(negedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      result.ready <= (received_powers >= CALM_FIRST && received_powers < CALM_LAST) ||
                      ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // monitor: samples both channels at the rising edge, predicts on each
  // operand transaction and checks each result transaction in order
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      operand_taken = 1'b0;
    end else begin
      operand_taken = operands.valid && operands.ready;
      if (operand_taken) begin
        expected_powers = {expected_powers,
                           pow_mod_prime(operands.base, operands.exponent)};
        accepted_ops++;
      end
      if (result.valid && result.ready) begin
        received_powers++;
        if (expected_powers.size() == 0) begin
          report_mismatch($sformatf("unexpected result power_mod=%0d", result.power_mod));
        end else begin
          if (result.power_mod !== expected_powers[0]) begin
            report_mismatch($sformatf("result %0d: power_mod=%0d, want %0d",
                                      received_powers, result.power_mod,
                                      expected_powers[0]));
          end
          void'(expected_powers.pop_front());
        end
      end
      // watchdog only counts cycles in which neither channel moves
      if (operand_taken || (result.valid && result.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
  end

  // watchdog
  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
    end
    $display("timeout after %0d cycles without a transaction", STALL_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned pick;
    int unsigned width;
    logic [63:0] near;
    // every input known from time zero
    operands.valid    = 1'b0;
    operands.base     = '0;
    operands.exponent = '0;
    result.ready      = 1'b0;
    operand_taken     = 1'b0;
    stall_cycles      = 0;
    mismatch_count    = 0;
    sent_ops          = 0;
    accepted_ops      = 0;
    received_powers   = 0;

    // directed: zero exponent (including 0^0 and a base that is a multiple
    // of the prime), bases at and above the prime, field extremes, fermat
    queue_op(32'd0, 32'd0);
    queue_op(32'd0, 32'd1);
    queue_op(32'(P1), 32'd0);
    queue_op(32'(P1), 32'd5);
    queue_op(32'(P2), 32'hFFFF_FFFF);
    queue_op(32'(P4), 32'd3);
    queue_op(32'(P1) + 32'd1, 32'd12345);
    queue_op(32'(P1) - 32'd1, 32'd2);
    queue_op(32'(P1) - 32'd1, 32'd3);
    queue_op(32'hFFFF_FFFF, 32'd0);
    queue_op(32'hFFFF_FFFF, 32'd1);
    queue_op(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_op(32'd1, 32'hFFFF_FFFF);
    queue_op(32'd2, 32'd29);
    queue_op(32'd2, 32'd30);
    queue_op(32'd2, 32'h8000_0000);
    queue_op(32'd2, 32'(P1) - 32'd2);
    queue_op(32'd123456789, 32'(P1) - 32'd2);
    queue_op(32'd3, 32'(P1) - 32'd1);
    queue_op(32'h8000_0000, 32'h5555_5555);
    queue_op(32'h5555_5555, 32'hAAAA_AAAA);
    queue_op(32'hAAAA_AAAA, 32'h5555_5555);

    // random: full-range operands most often, plus short exponents, bases near
    // multiples of the prime, fermat inverses and sparse exponents
    for (int unsigned n = 0; n < RANDOM_OPS; n++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        queue_op($urandom, $urandom);
      end else if (pick < 65) begin
        width = $urandom_range(10);
        queue_op($urandom, $urandom & ((32'd1 << width) - 32'd1));
      end else if (pick < 80) begin
        near = 64'(P1) * 64'($urandom_range(4)) + 64'($urandom_range(2));
        queue_op(near[31:0], $urandom);
      end else if (pick < 90) begin
        queue_op($urandom, 32'(P1) - 32'd2);
      end else if (pick < 95) begin
        queue_op($urandom, 32'd0);
      end else begin
        queue_op($urandom, 32'd1 << $urandom_range(31));
      end
    end
    total_ops = pending_ops.size();

    // synchronous reset, released at a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // wait until every operand is taken and every result has come back
    while (accepted_ops < total_ops || expected_powers.size() != 0) begin
      @(posedge clk);
    end
    // catch stray results after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mep_pkg.sv
rtl/mep_if.sv
rtl/mep_mul.sv
rtl/mep_fix.sv
rtl/modular_exponentiation_prime_core.sv
test/tb_modular_exponentiation_prime_core.sv
